[rtl/mtcd_pkg.sv]
// Package for the missing-tooth crank decoder: constants, codes and shared types.
`default_nettype none
package mtcd_pkg;

    // Parameter defaults
    localparam int TIME_BITS_DEF  = 32;
    localparam int TOOTH_BITS_DEF = 8;

    // Fixed field widths
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam int TIMEOUT_BITS  = 32;
    localparam int ALPHA_BITS    = 9;
    localparam int COUNT_BITS    = 32;
    localparam int SPEED_BITS    = 20;
    localparam int DIV_CNT_BITS  = $clog2(SPEED_BITS);

    // Speed numerator: one second in microseconds
    localparam logic [SPEED_BITS-1:0] SPEED_NUM = 20'd1000000;

    // Register reset values
    localparam logic [TIMEOUT_BITS-1:0] STALL_TIMEOUT_RST = 32'd200000;
    localparam logic [ALPHA_BITS-1:0]   FILTER_ALPHA_RST  = 9'd102;
    localparam logic [ALPHA_BITS-1:0]   ALPHA_ONE         = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ALPHA  = 1'd1;

    // Item actions
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DIFF,
        S_MUL,
        S_FILT,
        S_POLL,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage
`default_nettype wire

[rtl/mtcd_ifs.sv]
// Handshake interfaces for the item, result and configuration channels.
`default_nettype none
interface mtcd_in_if #(
    parameter int TIME_BITS = mtcd_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [TIME_BITS-1:0] timestamp_us;

    modport source (output valid, action, timestamp_us, input ready);
    modport sink   (input valid, action, timestamp_us, output ready);
endinterface

interface mtcd_out_if #(
    parameter int TIME_BITS  = mtcd_pkg::TIME_BITS_DEF,
    parameter int TOOTH_BITS = mtcd_pkg::TOOTH_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [TOOTH_BITS-1:0]            tooth_index;
    logic [mtcd_pkg::COUNT_BITS-1:0]  cylinder_events;
    logic [TIME_BITS-1:0]             tooth_period_us;
    logic [TIME_BITS-1:0]             filtered_period_us;
    logic [TIME_BITS-1:0]             gap_period_us;
    logic                             gap_seen;
    logic [mtcd_pkg::SPEED_BITS-1:0]  speed_value;

    modport source (output valid, tooth_index, cylinder_events, tooth_period_us,
                    filtered_period_us, gap_period_us, gap_seen, speed_value,
                    input ready);
    modport sink   (input valid, tooth_index, cylinder_events, tooth_period_us,
                    filtered_period_us, gap_period_us, gap_seen, speed_value,
                    output ready);
endinterface

interface mtcd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mtcd_pkg::CFG_IDX_BITS-1:0]  index;
    logic [mtcd_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/missing_tooth_crank_decoder_unit.sv]
// Top level of the missing-tooth crank decoder.
//
//  channel   dir   handshake            payload
//  i_item    in    valid/ready          action, timestamp_us
//  o_result  out   valid/ready          tooth_index .. speed_value (7 fields)
//  i_cfg     in    valid/ready (ready=1) index, data
//
// Edge transaction steps in the back end: pop, gap compare, filter diff,
//   filter multiply, filter add, result load. Poll: pop, timeout check, the
//   restoring speed divide when it runs, result load.
// A 2-entry queue sits between front and back; the front keeps accepting
//   until the queue fills while the back works or the result register waits
//   on o_result.ready.
// Reset is synchronous, active low; tooth, gap, filter and speed state clears
//   to zero and the registers return to timeout 200000 us and alpha 102/256.
`default_nettype none
module missing_tooth_crank_decoder_unit #(
    parameter int TIME_BITS  = mtcd_pkg::TIME_BITS_DEF,
    parameter int TOOTH_BITS = mtcd_pkg::TOOTH_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mtcd_in_if.sink     i_item,
    mtcd_out_if.source  o_result,
    mtcd_cfg_if.sink    i_cfg
);
    // configuration registers
    logic [mtcd_pkg::TIMEOUT_BITS-1:0] r_stall_timeout;
    logic [mtcd_pkg::ALPHA_BITS-1:0]   r_alpha;

    // queue plumbing
    mtcd_pkg::t_q_stat  q_stat;
    logic               q_push, q_pop;
    logic [TIME_BITS:0] q_in, q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_timeout <= mtcd_pkg::STALL_TIMEOUT_RST;
            r_alpha         <= mtcd_pkg::FILTER_ALPHA_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mtcd_pkg::CFG_STALL_TIMEOUT: r_stall_timeout <= i_cfg.data;
                mtcd_pkg::CFG_FILTER_ALPHA:
                    r_alpha <= i_cfg.data[mtcd_pkg::ALPHA_BITS-1:0];
                default: r_alpha <= r_alpha;
            endcase
        end
    end

    // front: period / elapsed time since the last edge
    mtcd_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_item.valid),
        .o_ready        (i_item.ready),
        .i_action       (i_item.action),
        .i_timestamp_us (i_item.timestamp_us),
        .i_q_stat       (q_stat),
        .o_push         (q_push),
        .o_push_data    (q_in)
    );

    mtcd_queue #(
        .WIDTH(TIME_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    // back: tooth/gap state, filter, speed divide, result register
    mtcd_back #(
        .TIME_BITS  (TIME_BITS),
        .TOOTH_BITS (TOOTH_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_stat             (q_stat),
        .i_q_data             (q_out),
        .o_pop                (q_pop),
        .i_stall_timeout      (r_stall_timeout),
        .i_alpha              (r_alpha),
        .o_valid              (o_result.valid),
        .i_ready              (o_result.ready),
        .o_tooth_index        (o_result.tooth_index),
        .o_cylinder_events    (o_result.cylinder_events),
        .o_tooth_period_us    (o_result.tooth_period_us),
        .o_filtered_period_us (o_result.filtered_period_us),
        .o_gap_period_us      (o_result.gap_period_us),
        .o_gap_seen           (o_result.gap_seen),
        .o_speed_value        (o_result.speed_value)
    );
endmodule
`default_nettype wire

[rtl/mtcd_front.sv]
// Front end: accepts items, takes the elapsed time since the last edge.
`default_nettype none
module mtcd_front #(
    parameter int TIME_BITS = mtcd_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_action,
    input  wire logic [TIME_BITS-1:0] i_timestamp_us,
    input  wire mtcd_pkg::t_q_stat    i_q_stat,
    output logic                      o_push,
    output logic [TIME_BITS:0]        o_push_data
);
    logic [TIME_BITS-1:0] r_edge_time;
    logic [TIME_BITS-1:0] n_edge_time;

    assign o_ready     = !i_q_stat.full;
    assign o_push      = i_valid && o_ready;
    // elapsed time wraps modulo 2^TIME_BITS
    assign o_push_data = {i_action, i_timestamp_us - r_edge_time};

    always_comb begin
        n_edge_time = r_edge_time;
        if (o_push && (i_action == mtcd_pkg::ACT_EDGE)) begin
            n_edge_time = i_timestamp_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_time <= '0;
        end else begin
            r_edge_time <= n_edge_time;
        end
    end
endmodule
`default_nettype wire

[rtl/mtcd_queue.sv]
// Small FIFO between the front end and the back end.
`default_nettype none
module mtcd_queue #(
    parameter int WIDTH = mtcd_pkg::TIME_BITS_DEF + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output mtcd_pkg::t_q_stat     o_stat
);
    localparam int DEPTH  = mtcd_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/mtcd_back.sv]
// Back end: gap test, tooth state, period filter, speed divider, result register.
`default_nettype none
module mtcd_back #(
    parameter int TIME_BITS  = mtcd_pkg::TIME_BITS_DEF,
    parameter int TOOTH_BITS = mtcd_pkg::TOOTH_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mtcd_pkg::t_q_stat                   i_q_stat,
    input  wire logic [TIME_BITS:0]                  i_q_data,
    output logic                                     o_pop,
    input  wire logic [mtcd_pkg::TIMEOUT_BITS-1:0]   i_stall_timeout,
    input  wire logic [mtcd_pkg::ALPHA_BITS-1:0]     i_alpha,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [TOOTH_BITS-1:0]                    o_tooth_index,
    output logic [mtcd_pkg::COUNT_BITS-1:0]          o_cylinder_events,
    output logic [TIME_BITS-1:0]                     o_tooth_period_us,
    output logic [TIME_BITS-1:0]                     o_filtered_period_us,
    output logic [TIME_BITS-1:0]                     o_gap_period_us,
    output logic                                     o_gap_seen,
    output logic [mtcd_pkg::SPEED_BITS-1:0]          o_speed_value
);
    localparam int GW    = TIME_BITS + 3;
    localparam int CMP_W = (TIME_BITS > mtcd_pkg::TIMEOUT_BITS) ? TIME_BITS
                                                                : mtcd_pkg::TIMEOUT_BITS;
    localparam int SB    = mtcd_pkg::SPEED_BITS;
    localparam int DW    = (TIME_BITS > SB + 1) ? TIME_BITS : SB + 1;
    localparam int PW    = TIME_BITS + mtcd_pkg::ALPHA_BITS;
    localparam int CB    = mtcd_pkg::DIV_CNT_BITS;

    mtcd_pkg::t_back_state r_state, n_state;

    // architectural state
    logic [TIME_BITS-1:0]           r_prev_period, r_normal, r_gap_period, r_smooth;
    logic [TOOTH_BITS-1:0]          r_tooth;
    logic [mtcd_pkg::COUNT_BITS-1:0] r_gap_cnt;
    logic [SB-1:0]                  r_speed;

    // working registers
    logic                  r_act;
    logic [TIME_BITS-1:0]  r_delta;
    logic                  r_gap;
    logic                  r_up;
    logic [TIME_BITS-1:0]  r_diff;
    logic [TIME_BITS-1:0]  r_scaled;
    logic [SB-1:0]         r_rem, r_quo;
    logic [CB-1:0]         r_cnt;

    // output register
    logic                  r_out_valid;

    logic                  out_free, out_load;
    logic [GW-1:0]         lhs_5p, rhs_3d;
    logic                  is_gap;
    logic [mtcd_pkg::ALPHA_BITS-1:0] alpha_sat;
    logic [PW-1:0]         product;
    logic                  timed_out, speed_ok;
    logic [SB:0]           trial;
    logic                  trial_ge;
    logic [SB-1:0]         n_rem, n_quo;

    assign out_free = !r_out_valid || i_ready;

    // period >= floor(5*prev/3)  <=>  5*prev <= 3*period + 2
    assign lhs_5p = ({3'b000, r_prev_period} << 2) + {3'b000, r_prev_period};
    assign rhs_3d = ({3'b000, r_delta} << 1) + {3'b000, r_delta} + GW'(2);
    assign is_gap = (lhs_5p <= rhs_3d);

    assign alpha_sat = (i_alpha > mtcd_pkg::ALPHA_ONE) ? mtcd_pkg::ALPHA_ONE : i_alpha;
    assign product   = PW'(r_diff) * PW'(alpha_sat);

    assign timed_out = (CMP_W'(r_delta) > CMP_W'(i_stall_timeout));
    assign speed_ok  = (r_tooth > TOOTH_BITS'(2)) && (r_normal != '0);

    // restoring division, one quotient bit per cycle
    assign trial    = {r_rem, mtcd_pkg::SPEED_NUM[r_cnt]};
    assign trial_ge = (DW'(trial) >= DW'(r_normal));
    assign n_rem    = trial_ge ? SB'(DW'(trial) - DW'(r_normal)) : SB'(trial);
    assign n_quo    = {r_quo[SB-2:0], trial_ge};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtcd_pkg::S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = (i_q_data[TIME_BITS] == mtcd_pkg::ACT_EDGE) ? mtcd_pkg::S_CMP
                                                                         : mtcd_pkg::S_POLL;
                end
            end
            mtcd_pkg::S_CMP:  n_state = mtcd_pkg::S_DIFF;
            mtcd_pkg::S_DIFF: n_state = mtcd_pkg::S_MUL;
            mtcd_pkg::S_MUL:  n_state = mtcd_pkg::S_FILT;
            mtcd_pkg::S_FILT: n_state = mtcd_pkg::S_DONE;
            mtcd_pkg::S_POLL: begin
                n_state = (!timed_out && speed_ok) ? mtcd_pkg::S_DIV : mtcd_pkg::S_DONE;
            end
            mtcd_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = mtcd_pkg::S_DONE;
                end
            end
            mtcd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mtcd_pkg::S_IDLE;
                end
            end
            default: n_state = mtcd_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            mtcd_pkg::S_IDLE: o_pop    = !i_q_stat.empty;
            mtcd_pkg::S_DONE: out_load = out_free;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mtcd_pkg::S_IDLE;
            r_prev_period <= '0;
            r_normal      <= '0;
            r_gap_period  <= '0;
            r_smooth      <= '0;
            r_tooth       <= '0;
            r_gap_cnt     <= '0;
            r_speed       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                mtcd_pkg::S_CMP: begin
                    if (is_gap) begin
                        r_tooth      <= TOOTH_BITS'(1);
                        r_gap_cnt    <= r_gap_cnt + 1'b1;
                        r_gap_period <= r_delta;
                    end else begin
                        r_tooth  <= r_tooth + 1'b1;
                        r_normal <= r_delta;
                    end
                    r_prev_period <= r_delta;
                end
                mtcd_pkg::S_FILT: begin
                    r_smooth <= r_up ? r_smooth + r_scaled : r_smooth - r_scaled;
                end
                mtcd_pkg::S_POLL: begin
                    if (timed_out) begin
                        r_speed <= '0;
                    end
                end
                mtcd_pkg::S_DIV: begin
                    if (r_cnt == '0) begin
                        r_speed <= n_quo;
                    end
                end
                default: begin
                    r_speed <= r_speed;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            mtcd_pkg::S_IDLE: begin
                r_act   <= i_q_data[TIME_BITS];
                r_delta <= i_q_data[TIME_BITS-1:0];
                r_gap   <= 1'b0;
            end
            mtcd_pkg::S_CMP: r_gap <= is_gap;
            mtcd_pkg::S_DIFF: begin
                r_up   <= (r_normal >= r_smooth);
                r_diff <= (r_normal >= r_smooth) ? r_normal - r_smooth
                                                 : r_smooth - r_normal;
            end
            mtcd_pkg::S_MUL: r_scaled <= product[TIME_BITS+7:8];
            mtcd_pkg::S_POLL: begin
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CB'(SB - 1);
            end
            mtcd_pkg::S_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
            end
            default: r_delta <= r_delta;
        endcase
        if (out_load) begin
            o_tooth_index        <= r_tooth;
            o_cylinder_events    <= r_gap_cnt;
            o_tooth_period_us    <= r_normal;
            o_filtered_period_us <= r_smooth;
            o_gap_period_us      <= r_gap_period;
            o_gap_seen           <= r_gap && (r_act == mtcd_pkg::ACT_EDGE);
            o_speed_value        <= r_speed;
        end
    end

    assign o_valid = r_out_valid;

    a_gap_sets_tooth_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtcd_pkg::S_CMP && is_gap) |=> (r_tooth == TOOTH_BITS'(1)))
        else $error("gap edge did not reset tooth index");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtcd_pkg::S_DIV) |-> (r_normal != '0))
        else $error("speed divider running on zero period");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != mtcd_pkg::S_IDLE))
        else $error("back end stayed idle after pop");

    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result load lost");
endmodule
`default_nettype wire

[tb/sv/mtcd_reading_check.sv]
// Checker for the crank decoder: predicts each reading and compares it with the result channel.
`timescale 1ns / 1ps
`default_nettype none
module mtcd_reading_check (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtcd_in_if        i_item,
    mtcd_out_if       i_result,
    mtcd_cfg_if       i_cfg,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int TB_TIME  = mtcd_pkg::TIME_BITS_DEF;
    localparam int TB_TOOTH = mtcd_pkg::TOOTH_BITS_DEF;

    typedef struct packed {
        logic [TB_TOOTH-1:0]             tooth_index;
        logic [mtcd_pkg::COUNT_BITS-1:0] cylinder_events;
        logic [TB_TIME-1:0]              tooth_period_us;
        logic [TB_TIME-1:0]              filtered_period_us;
        logic [TB_TIME-1:0]              gap_period_us;
        logic                            gap_seen;
        logic [mtcd_pkg::SPEED_BITS-1:0] speed_value;
    } t_crank_reading;

    // register copies
    logic [mtcd_pkg::TIMEOUT_BITS-1:0] stall_timeout;
    logic [mtcd_pkg::ALPHA_BITS-1:0]   alpha_q8;

    // decoder state copies
    logic [TB_TIME-1:0]              last_edge_ts;
    logic [TB_TIME-1:0]              last_period;
    logic [TB_TIME-1:0]              tooth_period;
    logic [TB_TIME-1:0]              gap_period;
    logic [TB_TOOTH-1:0]             tooth_idx;
    logic [mtcd_pkg::COUNT_BITS-1:0] gap_count;
    logic [TB_TIME-1:0]              smooth_period;
    logic [mtcd_pkg::SPEED_BITS-1:0] speed_hold;

    t_crank_reading expected_readings[$];
    int             fails = 0;

    task automatic decode_transaction(input logic act, input logic [TB_TIME-1:0] ts,
                                      output t_crank_reading rd);
        logic [TB_TIME-1:0]              elapsed;
        logic [TB_TIME+2:0]              five_prev;
        logic [TB_TIME+2:0]              threshold;
        logic [TB_TIME+9:0]              weighted;
        logic [mtcd_pkg::ALPHA_BITS-1:0] a;
        logic [31:0]                     quotient;
        logic                            is_gap;
        elapsed = ts - last_edge_ts;
        is_gap  = 1'b0;
        if (act == mtcd_pkg::ACT_EDGE) begin
            last_edge_ts = ts;
            // 5*prev/3 kept wide so the threshold never wraps
            five_prev = last_period * 3'd5;
            threshold = five_prev / 3;
            if ({3'b000, elapsed} >= threshold) begin
                is_gap     = 1'b1;
                tooth_idx  = TB_TOOTH'(1);
                gap_count  = gap_count + 1'b1;
                gap_period = elapsed;
            end else begin
                tooth_idx    = tooth_idx + 1'b1;
                tooth_period = elapsed;
            end
            a = (alpha_q8 > mtcd_pkg::ALPHA_ONE) ? mtcd_pkg::ALPHA_ONE : alpha_q8;
            if (tooth_period >= smooth_period) begin
                weighted      = a * (tooth_period - smooth_period);
                smooth_period = smooth_period + weighted[TB_TIME+7:8];
            end else begin
                weighted      = a * (smooth_period - tooth_period);
                smooth_period = smooth_period - weighted[TB_TIME+7:8];
            end
            last_period = elapsed;
        end else begin
            if (elapsed > stall_timeout) begin
                speed_hold = '0;
            end else if (tooth_idx > 2 && tooth_period != 0) begin
                quotient   = mtcd_pkg::SPEED_NUM / tooth_period;
                speed_hold = quotient[mtcd_pkg::SPEED_BITS-1:0];
            end
        end
        rd.tooth_index        = tooth_idx;
        rd.cylinder_events    = gap_count;
        rd.tooth_period_us    = tooth_period;
        rd.filtered_period_us = smooth_period;
        rd.gap_period_us      = gap_period;
        rd.gap_seen           = is_gap;
        rd.speed_value        = speed_hold;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_crank_reading rd;
        if (!i_rst_n) begin
            stall_timeout = mtcd_pkg::STALL_TIMEOUT_RST;
            alpha_q8      = mtcd_pkg::FILTER_ALPHA_RST;
            last_edge_ts  = '0;
            last_period   = '0;
            tooth_period  = '0;
            gap_period    = '0;
            tooth_idx     = '0;
            gap_count     = '0;
            smooth_period = '0;
            speed_hold    = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == mtcd_pkg::CFG_STALL_TIMEOUT)
                    stall_timeout = i_cfg.data;
                else if (i_cfg.index == mtcd_pkg::CFG_FILTER_ALPHA)
                    alpha_q8 = i_cfg.data[mtcd_pkg::ALPHA_BITS-1:0];
            end
            if (i_item.valid && i_item.ready) begin
                decode_transaction(i_item.action, i_item.timestamp_us, rd);
                expected_readings.push_back(rd);
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t ns: result transaction with no reading expected", $time);
                    fails++;
                end else begin
                    rd = expected_readings.pop_front();
                    check_field("tooth_index", 32'(rd.tooth_index), 32'(i_result.tooth_index));
                    check_field("cylinder_events", rd.cylinder_events,
                                i_result.cylinder_events);
                    check_field("tooth_period_us", rd.tooth_period_us,
                                i_result.tooth_period_us);
                    check_field("filtered_period_us", rd.filtered_period_us,
                                i_result.filtered_period_us);
                    check_field("gap_period_us", rd.gap_period_us, i_result.gap_period_us);
                    check_field("gap_seen", 32'(rd.gap_seen), 32'(i_result.gap_seen));
                    check_field("speed_value", 32'(rd.speed_value), 32'(i_result.speed_value));
                end
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= fails;
    end

endmodule
`default_nettype wire

[tb/sv/missing_tooth_crank_decoder_unit_tb.sv]
// Testbench top for the crank decoder: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module missing_tooth_crank_decoder_unit_tb;

    logic i_clk;
    logic i_rst_n;

    mtcd_in_if  item_if ();
    mtcd_out_if result_if ();
    mtcd_cfg_if cfg_if ();

    int fail_count;
    int pending;

    missing_tooth_crank_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    mtcd_reading_check u_reading_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_if),
        .i_result     (result_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal run, with source gaps and sink stalls on
    // every transaction, ends well before this limit.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus bookkeeping
    logic                              src_idle_en;   // source may insert gaps
    logic                              sink_idle_en;  // result side may drop ready
    logic [31:0]                       last_edge;     // timestamp of the last edge sent
    logic [mtcd_pkg::TIMEOUT_BITS-1:0] cur_timeout;
    logic [mtcd_pkg::ALPHA_BITS-1:0]   cur_alpha;
    logic [31:0]                       base;
    logic [31:0]                       step;
    int                                n_edges;
    int                                n_polls;
    int                                n_settings;
    int                                phase;
    int                                phase_end;
    int                                kind;
    int                                teeth;
    int                                revs;
    int                                stall_left;

    // Result-side backpressure: ready drops in random bursts while
    // sink_idle_en is set, otherwise it stays high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_left      <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (result_if.ready && sink_idle_en && $urandom_range(0, 4) == 0) begin
            result_if.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 7);
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // One input transaction. valid is left high on return so a following
    // transaction can go back to back; a source gap lowers it first.
    task automatic send_item(input logic act, input logic [31:0] ts);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.action       <= act;
        item_if.timestamp_us <= ts;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        if (act == mtcd_pkg::ACT_EDGE) begin
            last_edge = ts;
            n_edges++;
        end else begin
            n_polls++;
        end
    endtask

    // Stop the source and wait until every expected reading has come back.
    task automatic drain();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Both registers in two back-to-back transactions; valid is held high
    // between them so it never gets two updates in one step.
    task automatic load_regs(input logic [mtcd_pkg::TIMEOUT_BITS-1:0] timeout,
                             input logic [mtcd_pkg::ALPHA_BITS-1:0] alpha);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= mtcd_pkg::CFG_STALL_TIMEOUT;
        cfg_if.data  <= timeout;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.index <= mtcd_pkg::CFG_FILTER_ALPHA;
        cfg_if.data  <= mtcd_pkg::CFG_DATA_BITS'(alpha);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        // every input set here is known from time zero
        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.action       <= mtcd_pkg::ACT_EDGE;
        item_if.timestamp_us <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= mtcd_pkg::CFG_STALL_TIMEOUT;
        cfg_if.data          <= '0;
        sink_idle_en         <= 1'b0;
        src_idle_en  = 1'b0;
        last_edge    = '0;
        cur_timeout  = mtcd_pkg::STALL_TIMEOUT_RST;
        cur_alpha    = mtcd_pkg::FILTER_ALPHA_RST;
        n_edges      = 0;
        n_polls      = 0;
        n_settings   = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed part, reset register values ----------------
        send_item(mtcd_pkg::ACT_POLL, 32'd0);     // poll before any edge: speed held at 0
        send_item(mtcd_pkg::ACT_EDGE, 32'd1000);  // first edge: previous period 0, so gap
        send_item(mtcd_pkg::ACT_EDGE, 32'd2000);  // 1000 < 1666: normal tooth, index 2
        send_item(mtcd_pkg::ACT_POLL, 32'd2100);  // index 2: speed still held
        send_item(mtcd_pkg::ACT_EDGE, 32'd3000);
        send_item(mtcd_pkg::ACT_POLL, 32'd3001);  // index 3: speed = 1e6/1000
        send_item(mtcd_pkg::ACT_EDGE, 32'd4000);
        send_item(mtcd_pkg::ACT_EDGE, 32'd6000);  // 2000 >= 1666: gap
        send_item(mtcd_pkg::ACT_EDGE, 32'd6001);  // tiny normal period
        send_item(mtcd_pkg::ACT_EDGE, 32'd6002);  // prev 1, threshold floor(5/3)=1: gap
        send_item(mtcd_pkg::ACT_EDGE, 32'd6004);
        send_item(mtcd_pkg::ACT_POLL, last_edge + 32'd200000); // elapsed == timeout
        send_item(mtcd_pkg::ACT_POLL, last_edge + 32'd200001); // one past: speed to 0
        send_item(mtcd_pkg::ACT_EDGE, last_edge);              // zero period edge
        send_item(mtcd_pkg::ACT_POLL, last_edge + 32'd5);      // zero normal period: held
        send_item(mtcd_pkg::ACT_EDGE, 32'hFFFF_FF00);  // long period, near timer wrap
        send_item(mtcd_pkg::ACT_EDGE, 32'h0000_0010);  // period across the wrap
        send_item(mtcd_pkg::ACT_EDGE, 32'h0000_000F);  // period 2^32-1: gap
        send_item(mtcd_pkg::ACT_EDGE, 32'h0000_0073);  // 5*prev overflows 32 bits: never a gap
        send_item(mtcd_pkg::ACT_EDGE, 32'h0000_0072);  // full-scale period again
        send_item(mtcd_pkg::ACT_POLL, 32'hFFFF_FFFF);
        send_item(mtcd_pkg::ACT_EDGE, 32'h0000_00D6);
        send_item(mtcd_pkg::ACT_POLL, 32'h0000_00D6);

        // ---------------- random phases, one register setting each ----------------
        for (phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: begin cur_timeout = 32'd200000;     cur_alpha = 9'd102; end
                1: begin cur_timeout = 32'd0;          cur_alpha = 9'd0;   end
                2: begin cur_timeout = 32'hFFFF_FFFF;  cur_alpha = 9'd256; end
                3: begin cur_timeout = $urandom_range(1000, 1000000); cur_alpha = 9'd511; end
                4: begin
                    cur_timeout = 32'd200000;
                    cur_alpha   = mtcd_pkg::ALPHA_BITS'($urandom_range(257, 510));
                end
                5: begin
                    cur_timeout = $urandom;
                    cur_alpha   = mtcd_pkg::ALPHA_BITS'($urandom_range(0, 511));
                end
                6: begin cur_timeout = $urandom_range(0, 300000); cur_alpha = 9'd1; end
                default: begin cur_timeout = 32'd200000; cur_alpha = 9'd102; end
            endcase
            load_regs(cur_timeout, cur_alpha);
            phase_end = n_edges + n_polls + 170;

            // one long run without a gap so the tooth index wraps past 255
            if (phase == 4)
                repeat (270) send_item(mtcd_pkg::ACT_EDGE, last_edge + 32'd37);

            while (n_edges + n_polls < phase_end) begin
                // the final phase runs without any idling on either side
                src_idle_en   = (phase != 7) && ($urandom_range(0, 3) != 0);
                sink_idle_en <= (phase != 7) && ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 3))
                    0: base = $urandom_range(1, 64);
                    1: base = $urandom_range(64, 5000);
                    2: base = $urandom_range(5000, 200000);
                    default: base = $urandom_range(200000, 32'h2000_0000);
                endcase
                kind = $urandom_range(0, 9);
                if (kind <= 5) begin
                    // well-formed wheel: jittered teeth, then a 1- or 2-tooth gap
                    teeth = $urandom_range(3, 40);
                    revs  = $urandom_range(1, 3);
                    repeat (revs) begin
                        for (int t = 1; t <= teeth; t++) begin
                            if (t == teeth)
                                step = base * $urandom_range(2, 3);
                            else
                                step = base - base / 16 + $urandom_range(0, base / 8);
                            send_item(mtcd_pkg::ACT_EDGE, last_edge + step);
                            if ($urandom_range(0, 4) == 0)
                                send_item(mtcd_pkg::ACT_POLL,
                                          last_edge + $urandom_range(0, base / 2));
                        end
                    end
                end else if (kind == 6) begin
                    // noise: fully random action and timestamp
                    repeat ($urandom_range(1, 6))
                        send_item(1'($urandom_range(0, 1)), $urandom);
                end else if (kind == 7) begin
                    // broken wheel: periods wander between half and double
                    repeat ($urandom_range(2, 12)) begin
                        send_item(mtcd_pkg::ACT_EDGE,
                                  last_edge + $urandom_range(base / 2, base * 2));
                        if ($urandom_range(0, 2) == 0)
                            send_item(mtcd_pkg::ACT_POLL, last_edge + $urandom_range(0, base));
                    end
                end else if (kind == 8) begin
                    // stall boundary: elapsed equal to or one past the timeout
                    send_item(mtcd_pkg::ACT_POLL,
                              last_edge + cur_timeout + $urandom_range(0, 1));
                end else begin
                    // jump the timer close to its wrap point
                    send_item(mtcd_pkg::ACT_EDGE, 32'hFFFF_FFFF - $urandom_range(0, 2000));
                end
            end
        end

        drain();
        sink_idle_en <= 1'b0;
        repeat (40) @(posedge i_clk);

        $display("Sent %0d edge and %0d poll transactions over %0d register settings,",
                 n_edges, n_polls, n_settings);
        $display("with tooth-index wrap, timer wrap, stall boundaries and alpha saturation.");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
